FILE: design/cdcp_pkg.sv
// Shared types, constants and helper functions for the contact cone projection block.
package cdcp_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_W = 16;
   localparam int MU_W   = 20;
   localparam int MIND_W = 17;
   localparam int QUO_W  = WORD_W + FRAC_W;
   localparam int M_W    = 51;
   localparam int ROOT_W = 32;

   typedef enum logic [1:0] {
      ST_INSIDE    = 2'd0,
      ST_PROJECTED = 2'd1,
      ST_SEPARATED = 2'd2,
      ST_BAD_DIAG  = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] offset_normal;
      logic [WORD_W-1:0] offset_tan1;
      logic [WORD_W-1:0] offset_tan2;
      logic [WORD_W-1:0] diag_normal;
      logic [WORD_W-1:0] diag_tan1;
      logic [WORD_W-1:0] diag_tan2;
      logic [MU_W-1:0]   friction_coef;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] force_normal;
      logic [WORD_W-1:0] force_tan1;
      logic [WORD_W-1:0] force_tan2;
      status_type        status;
   } rsp_type;

   // magnitude of a two's complement word
   function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] res;
      res = x[WORD_W-1] ? (~x + 32'd1) : x;
      return res;
   endfunction

   // signed word from magnitude and sign, saturated
   function automatic logic [WORD_W-1:0] sat_from_mag(input logic [QUO_W-1:0] m,
                                                      input logic neg);
      logic [WORD_W-1:0] res;
      if (m > 48'h0000_7FFF_FFFF) begin
         res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         res = neg ? (~m[WORD_W-1:0] + 32'd1) : m[WORD_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: design/cdcp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband delay line.
module cdcp_div_pipe #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [DEN_W-1:0]  rem_init,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   logic              v_ff    [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic              pv;
         logic [DEN_W-1:0]  prem;
         logic [DEN_W-1:0]  pden;
         logic [NUM_W-1:0]  pnum;
         logic [NUM_W-1:0]  pquo;
         logic [SIDE_W-1:0] pside;
         logic [DEN_W:0]    trial;
         logic [DEN_W:0]    diff;
         logic              qbit;
         logic [DEN_W-1:0]  rem_in;

         if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = rem_init;
            assign pden  = den;
            assign pnum  = num;
            assign pquo  = '0;
            assign pside = side_in;
         end else begin : g_next
            assign pv    = v_ff[k-1];
            assign prem  = rem_ff[k-1];
            assign pden  = den_ff[k-1];
            assign pnum  = num_ff[k-1];
            assign pquo  = quo_ff[k-1];
            assign pside = side_ff[k-1];
         end

         // shift in one dividend bit, subtract when it fits
         assign trial  = {prem, pnum[NUM_W-1]};
         assign diff   = trial - {1'b0, pden};
         assign qbit   = ~diff[DEN_W];
         assign rem_in = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               den_ff[k]  <= pden;
               num_ff[k]  <= pnum << 1;
               quo_ff[k]  <= {pquo[NUM_W-2:0], qbit};
               side_ff[k] <= pside;
            end
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= pv;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[NUM_W-1];
   assign quo       = quo_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

endmodule

FILE: design/cdcp_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a sideband delay line.
module cdcp_sqrt_pipe #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] rad,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   root,
   output logic [SIDE_W-1:0]   side_out
);

   localparam int RAD_W = 2 * ROOT_W;

   logic              v_ff    [ROOT_W];
   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         logic              pv;
         logic [ROOT_W+1:0] prem;
         logic [ROOT_W-1:0] proot;
         logic [RAD_W-1:0]  prad;
         logic [SIDE_W-1:0] pside;
         logic [ROOT_W+1:0] cur;
         logic [ROOT_W+1:0] test;
         logic              ge;

         if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = rad;
            assign pside = side_in;
         end else begin : g_next
            assign pv    = v_ff[k-1];
            assign prem  = rem_ff[k-1];
            assign proot = root_ff[k-1];
            assign prad  = rad_ff[k-1];
            assign pside = side_ff[k-1];
         end

         // bring down two radicand bits, try root*4+1
         assign cur  = {prem[ROOT_W-1:0], prad[RAD_W-1:RAD_W-2]};
         assign test = {proot, 2'b01};
         assign ge   = (cur >= test);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= ge ? (cur - test) : cur;
               root_ff[k] <= {proot[ROOT_W-2:0], ge};
               rad_ff[k]  <= prad << 2;
               side_ff[k] <= pside;
            end
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= pv;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

FILE: design/cdcp_proj_lane.sv
// One tangential lane: scales a force by m / root onto the friction cone, saturated.
module cdcp_proj_lane #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [cdcp_pkg::WORD_W-1:0] r,
   input  logic [cdcp_pkg::ROOT_W-1:0] root,
   input  logic [cdcp_pkg::M_W-1:0]    m,
   input  logic [SIDE_W-1:0]         side_in,
   output logic                      out_valid,
   output logic [cdcp_pkg::WORD_W-1:0] force_out,
   output logic [SIDE_W-1:0]         side_out
);
   import cdcp_pkg::*;

   localparam int DSIDE_W = 2 + M_W + SIDE_W;

   // stage A: magnitude, top quotient bit
   logic [WORD_W-1:0] magr;
   logic [ROOT_W-1:0] root_fix;
   logic              ge;
   logic              a_v_ff;
   logic [ROOT_W-1:0] a_rem_ff;
   logic [ROOT_W-1:0] a_root_ff;
   logic              a_top_ff;
   logic              a_neg_ff;
   logic [M_W-1:0]    a_m_ff;
   logic [SIDE_W-1:0] a_side_ff;

   assign magr     = mag32(r);
   assign root_fix = (root == '0) ? {{(ROOT_W-1){1'b0}}, 1'b1} : root;
   assign ge       = (magr >= root_fix);

   always_ff @(posedge clock) begin
      if (en) begin
         a_rem_ff  <= ge ? (magr - root_fix) : magr;
         a_root_ff <= root_fix;
         a_top_ff  <= ge;
         a_neg_ff  <= r[WORD_W-1];
         a_m_ff    <= m;
         a_side_ff <= side_in;
      end
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
      end
   end

   // remaining 32 quotient bits of |r| * 2^32 / root
   logic               d_v;
   logic [ROOT_W-1:0]  d_quo;
   logic [DSIDE_W-1:0] d_side;

   cdcp_div_pipe #(
      .NUM_W  (ROOT_W),
      .DEN_W  (ROOT_W),
      .SIDE_W (DSIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_v_ff),
      .num       ('0),
      .den       (a_root_ff),
      .rem_init  (a_rem_ff),
      .side_in   ({a_top_ff, a_neg_ff, a_m_ff, a_side_ff}),
      .out_valid (d_v),
      .quo       (d_quo),
      .side_out  (d_side)
   );

   // stage B: t times m in two partial products
   logic [ROOT_W:0]   t;
   logic [M_W-1:0]    dm;
   logic [64:0]       prod_lo;
   logic [51:0]       prod_hi;
   logic              b_v_ff;
   logic [64:0]       b_lo_ff;
   logic [51:0]       b_hi_ff;
   logic              b_neg_ff;
   logic [SIDE_W-1:0] b_side_ff;

   assign t       = {d_side[DSIDE_W-1], d_quo};
   assign dm      = d_side[SIDE_W +: M_W];
   assign prod_lo = {32'b0, t} * {33'b0, dm[31:0]};
   assign prod_hi = {19'b0, t} * {33'b0, dm[M_W-1:32]};

   always_ff @(posedge clock) begin
      if (en) begin
         b_lo_ff   <= prod_lo;
         b_hi_ff   <= prod_hi;
         b_neg_ff  <= d_side[DSIDE_W-2];
         b_side_ff <= d_side[SIDE_W-1:0];
      end
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= d_v;
      end
   end

   // stage C: sum, drop 48 fraction bits, saturate with sign
   logic [84:0]       prod_sum;
   logic              c_v_ff;
   logic [WORD_W-1:0] c_force_ff;
   logic [SIDE_W-1:0] c_side_ff;

   assign prod_sum = {20'b0, b_lo_ff} + {1'b0, b_hi_ff, 32'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         c_force_ff <= sat_from_mag({11'b0, prod_sum[84:48]}, b_neg_ff);
         c_side_ff  <= b_side_ff;
      end
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
   end

   assign out_valid = c_v_ff;
   assign force_out = c_force_ff;
   assign side_out  = c_side_ff;

endmodule

FILE: design/contact_diag_cone_projection_unit.sv
// Contact cone projection unit: a fully pipelined datapath that accepts one
// contact per clock while req_stall is low and returns its reaction, in order.
// The pipeline is built from the three 48-stage force divider lanes, the 32-stage
// square root and the two 35-stage tangential scaling lanes (a 32-stage
// divider plus three registers), plus four registers for the saturated
// forces, squares, square norm and cone limit, and the output register. The
// whole pipeline advances together; a skid register behind the output
// register lets one more item in while a result waits, after which req_stall
// rises until the result is taken.
// min_diagonal resets to 1 and is written through the csr port, which is
// always ready.
module contact_diag_cone_projection_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  cdcp_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output cdcp_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cdcp_pkg::MIND_W-1:0]  csr_data
);
   import cdcp_pkg::*;

   localparam int S0_W = 1 + MU_W + 2;
   localparam int SQ_W = 3 * WORD_W + M_W + 3;
   localparam int L1_W = 2 * WORD_W + 3;

   logic adv;
   logic skid_valid_ff;

   // configuration register
   logic [MIND_W-1:0] min_diag_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_diag_ff <= {{(MIND_W-1){1'b0}}, 1'b1};
      end else if (csr_valid) begin
         min_diag_ff <= csr_data;
      end
   end

   // pipeline moves as long as the skid slot is free
   assign adv       = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // separation and diagonal checks
   logic              sep;
   logic              bad;
   logic [WORD_W-1:0] mind_w;

   assign mind_w = {{(WORD_W-MIND_W){1'b0}}, min_diag_ff};
   assign sep    = $signed(req_data.offset_normal) > 32'sd0;
   assign bad    = ($signed(req_data.diag_normal) < $signed(mind_w))
                || ($signed(req_data.diag_tan1) < $signed(mind_w))
                || ($signed(req_data.diag_tan2) < $signed(mind_w))
                || ($signed(req_data.diag_normal) <= 32'sd0)
                || ($signed(req_data.diag_tan1) <= 32'sd0)
                || ($signed(req_data.diag_tan2) <= 32'sd0);

   // three force divider lanes: r = -(q * 2^16) / d
   logic             dv0, dv1, dv2;
   logic [QUO_W-1:0] quo0, quo1, quo2;
   logic [S0_W-1:0]  dside0;
   logic             dside1, dside2;

   cdcp_div_pipe #(.NUM_W(QUO_W), .DEN_W(WORD_W), .SIDE_W(S0_W)) u_div_n (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .num       ({mag32(req_data.offset_normal), {FRAC_W{1'b0}}}),
      .den       (req_data.diag_normal),
      .rem_init  ('0),
      .side_in   ({~req_data.offset_normal[WORD_W-1] && sep, req_data.friction_coef,
                   sep, bad}),
      .out_valid (dv0),
      .quo       (quo0),
      .side_out  (dside0)
   );

   cdcp_div_pipe #(.NUM_W(QUO_W), .DEN_W(WORD_W), .SIDE_W(1)) u_div_t1 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .num       ({mag32(req_data.offset_tan1), {FRAC_W{1'b0}}}),
      .den       (req_data.diag_tan1),
      .rem_init  ('0),
      .side_in   ($signed(req_data.offset_tan1) > 32'sd0),
      .out_valid (dv1),
      .quo       (quo1),
      .side_out  (dside1)
   );

   cdcp_div_pipe #(.NUM_W(QUO_W), .DEN_W(WORD_W), .SIDE_W(1)) u_div_t2 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .num       ({mag32(req_data.offset_tan2), {FRAC_W{1'b0}}}),
      .den       (req_data.diag_tan2),
      .rem_init  ('0),
      .side_in   ($signed(req_data.offset_tan2) > 32'sd0),
      .out_valid (dv2),
      .quo       (quo2),
      .side_out  (dside2)
   );

   // stage R: saturated forces
   logic              r_v_ff;
   logic [WORD_W-1:0] r_f0_ff, r_f1_ff, r_f2_ff;
   logic [MU_W-1:0]   r_mu_ff;
   logic              r_sep_ff, r_bad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r_f0_ff  <= sat_from_mag(quo0, dside0[S0_W-1]);
         r_f1_ff  <= sat_from_mag(quo1, dside1);
         r_f2_ff  <= sat_from_mag(quo2, dside2);
         r_mu_ff  <= dside0[2 +: MU_W];
         r_sep_ff <= dside0[1];
         r_bad_ff <= dside0[0];
      end
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (adv) begin
         r_v_ff <= dv0 & dv1 & dv2;
      end
   end

   // stage S1: tangential squares and cone limit m = mu * r0
   logic [WORD_W-1:0]   a1, a2;
   logic                s1_v_ff;
   logic [2*WORD_W-1:0] s1_sq1_ff, s1_sq2_ff;
   logic [M_W-1:0]      s1_m_ff;
   logic [WORD_W-1:0]   s1_f0_ff, s1_f1_ff, s1_f2_ff;
   logic                s1_sep_ff, s1_bad_ff;

   assign a1 = mag32(r_f1_ff);
   assign a2 = mag32(r_f2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sq1_ff <= {32'b0, a1} * {32'b0, a1};
         s1_sq2_ff <= {32'b0, a2} * {32'b0, a2};
         s1_m_ff   <= {{(M_W-MU_W){1'b0}}, r_mu_ff} * {20'b0, r_f0_ff[WORD_W-2:0]};
         s1_f0_ff  <= r_f0_ff;
         s1_f1_ff  <= r_f1_ff;
         s1_f2_ff  <= r_f2_ff;
         s1_sep_ff <= r_sep_ff;
         s1_bad_ff <= r_bad_ff;
      end
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= r_v_ff;
      end
   end

   // stage S2: square norm and partial products of m^2
   logic                s2_v_ff;
   logic [2*WORD_W-1:0] s2_mrn_ff;
   logic [63:0]         s2_pll_ff;
   logic [50:0]         s2_plh_ff;
   logic [37:0]         s2_phh_ff;
   logic [M_W-1:0]      s2_m_ff;
   logic [WORD_W-1:0]   s2_f0_ff, s2_f1_ff, s2_f2_ff;
   logic                s2_sep_ff, s2_bad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mrn_ff <= s1_sq1_ff + s1_sq2_ff;
         s2_pll_ff <= {32'b0, s1_m_ff[31:0]} * {32'b0, s1_m_ff[31:0]};
         s2_plh_ff <= {19'b0, s1_m_ff[31:0]} * {32'b0, s1_m_ff[M_W-1:32]};
         s2_phh_ff <= {19'b0, s1_m_ff[M_W-1:32]} * {19'b0, s1_m_ff[M_W-1:32]};
         s2_m_ff   <= s1_m_ff;
         s2_f0_ff  <= s1_f0_ff;
         s2_f1_ff  <= s1_f1_ff;
         s2_f2_ff  <= s1_f2_ff;
         s2_sep_ff <= s1_sep_ff;
         s2_bad_ff <= s1_bad_ff;
      end
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   // stage S3: m^2 assembled
   logic                s3_v_ff;
   logic [101:0]        s3_m2_ff;
   logic [2*WORD_W-1:0] s3_mrn_ff;
   logic [M_W-1:0]      s3_m_ff;
   logic [WORD_W-1:0]   s3_f0_ff, s3_f1_ff, s3_f2_ff;
   logic                s3_sep_ff, s3_bad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_m2_ff  <= {38'b0, s2_pll_ff} + {18'b0, s2_plh_ff, 33'b0}
                    + {s2_phh_ff, 64'b0};
         s3_mrn_ff <= s2_mrn_ff;
         s3_m_ff   <= s2_m_ff;
         s3_f0_ff  <= s2_f0_ff;
         s3_f1_ff  <= s2_f1_ff;
         s3_f2_ff  <= s2_f2_ff;
         s3_sep_ff <= s2_sep_ff;
         s3_bad_ff <= s2_bad_ff;
      end
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   // cone test: mrn * 2^32 > m^2, then square root of mrn
   logic              proj;
   logic              sq_v;
   logic [ROOT_W-1:0] sq_root;
   logic [SQ_W-1:0]   sq_side;

   assign proj = {6'b0, s3_mrn_ff, 32'b0} > s3_m2_ff;

   cdcp_sqrt_pipe #(.ROOT_W(ROOT_W), .SIDE_W(SQ_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_v_ff),
      .rad       (s3_mrn_ff),
      .side_in   ({s3_f0_ff, s3_f1_ff, s3_f2_ff, s3_m_ff, proj, s3_sep_ff, s3_bad_ff}),
      .out_valid (sq_v),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   // two tangential projection lanes
   logic              lv1, lv2;
   logic [WORD_W-1:0] pf1, pf2;
   logic [L1_W-1:0]   lside1;
   logic [WORD_W-1:0] lside2;
   logic [WORD_W-1:0] sq_f0, sq_f1, sq_f2;
   logic [M_W-1:0]    sq_m;

   assign sq_f0 = sq_side[SQ_W-1 -: WORD_W];
   assign sq_f1 = sq_side[SQ_W-1-WORD_W -: WORD_W];
   assign sq_f2 = sq_side[SQ_W-1-2*WORD_W -: WORD_W];
   assign sq_m  = sq_side[3 +: M_W];

   cdcp_proj_lane #(.SIDE_W(L1_W)) u_lane1 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_v),
      .r         (sq_f1),
      .root      (sq_root),
      .m         (sq_m),
      .side_in   ({sq_f0, sq_f1, sq_side[2:0]}),
      .out_valid (lv1),
      .force_out (pf1),
      .side_out  (lside1)
   );

   cdcp_proj_lane #(.SIDE_W(WORD_W)) u_lane2 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_v),
      .r         (sq_f2),
      .root      (sq_root),
      .m         (sq_m),
      .side_in   (sq_f2),
      .out_valid (lv2),
      .force_out (pf2),
      .side_out  (lside2)
   );

   // merge lanes into one result item
   logic    pipe_valid;
   rsp_type pipe_data;

   assign pipe_valid = lv1 & lv2;

   always_comb begin
      pipe_data.force_normal = lside1[L1_W-1 -: WORD_W];
      pipe_data.force_tan1   = lside1[L1_W-1-WORD_W -: WORD_W];
      pipe_data.force_tan2   = lside2;
      pipe_data.status       = ST_INSIDE;
      priority if (lside1[1]) begin
         pipe_data.force_normal = '0;
         pipe_data.force_tan1   = '0;
         pipe_data.force_tan2   = '0;
         pipe_data.status       = ST_SEPARATED;
      end else if (lside1[0]) begin
         pipe_data.force_normal = '0;
         pipe_data.force_tan1   = '0;
         pipe_data.force_tan2   = '0;
         pipe_data.status       = ST_BAD_DIAG;
      end else if (lside1[2]) begin
         pipe_data.force_tan1 = pf1;
         pipe_data.force_tan2 = pf2;
         pipe_data.status     = ST_PROJECTED;
      end else begin
         pipe_data.status = ST_INSIDE;
      end
   end

   // output register with one skid slot
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = pipe_valid;
            rsp_data_in  = pipe_data;
         end
      end else if (adv && pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the contact cone projection unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cdcp_pkg::*;

   localparam int LATENCY   = 120;
   localparam int CYC_LIMIT = 400000;
   localparam int RAND_ITEMS = 900;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [MIND_W-1:0] csr_data;

   req_type contact_q[$];
   rsp_type force_expect_q[$];
   logic [MIND_W-1:0] min_diag;
   int unsigned cyc;
   int unsigned force_count;
   int unsigned hold_left;
   bit hold_done;
   bit failed;

   contact_diag_cone_projection_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] clamp_word(input logic [63:0] m, input bit neg);
      if (m > 64'h7FFF_FFFF) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return neg ? WORD_W'(-m) : WORD_W'(m);
   endfunction

   // -(q * 2^16) / d, truncated toward zero, saturated
   function automatic logic [WORD_W-1:0] reaction(input logic [WORD_W-1:0] q,
                                                  input logic [WORD_W-1:0] d);
      longint qs;
      logic [63:0] qm;
      logic [63:0] quot;
      qs = longint'($signed(q));
      qm = (qs < 0) ? 64'(-qs) : 64'(qs);
      quot = (qm << FRAC_W) / 64'(d);
      return clamp_word(quot, qs > 0);
   endfunction

   function automatic logic [63:0] abs_word(input logic [WORD_W-1:0] x);
      return x[WORD_W-1] ? 64'(-longint'($signed(x))) : 64'(x);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale one tangential force by m / s keeping its sign
   function automatic logic [WORD_W-1:0] onto_cone(input logic [WORD_W-1:0] r,
                                                   input logic [63:0] m,
                                                   input logic [63:0] s);
      logic [63:0] t;
      logic [127:0] p;
      logic [127:0] sh;
      t = (abs_word(r) << 32) / s;
      p = 128'(t) * 128'(m);
      sh = p >> 48;
      return clamp_word((sh > 128'h7FFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : sh[63:0],
                        r[WORD_W-1]);
   endfunction

   function automatic rsp_type predict_force(input req_type c, input logic [MIND_W-1:0] mind);
      rsp_type o;
      longint d0;
      longint d1;
      longint d2;
      longint mn;
      logic [63:0] a1;
      logic [63:0] a2;
      logic [63:0] mrn;
      logic [63:0] m;
      logic [63:0] s;
      logic [127:0] lhs;
      logic [127:0] rhs;
      o = '0;
      d0 = longint'($signed(c.diag_normal));
      d1 = longint'($signed(c.diag_tan1));
      d2 = longint'($signed(c.diag_tan2));
      mn = longint'(mind);
      if ($signed(c.offset_normal) > 0) begin
         o.status = ST_SEPARATED;
      end else if (d0 < mn || d1 < mn || d2 < mn || d0 <= 0 || d1 <= 0 || d2 <= 0) begin
         o.status = ST_BAD_DIAG;
      end else begin
         o.force_normal = reaction(c.offset_normal, c.diag_normal);
         o.force_tan1 = reaction(c.offset_tan1, c.diag_tan1);
         o.force_tan2 = reaction(c.offset_tan2, c.diag_tan2);
         a1 = abs_word(o.force_tan1);
         a2 = abs_word(o.force_tan2);
         mrn = a1 * a1 + a2 * a2;
         m = 64'(c.friction_coef) * 64'(o.force_normal);
         lhs = 128'(mrn) << 32;
         rhs = 128'(m) * 128'(m);
         if (lhs > rhs) begin
            s = floor_sqrt(mrn);
            if (s == 0) s = 1;
            o.force_tan1 = onto_cone(o.force_tan1, m, s);
            o.force_tan2 = onto_cone(o.force_tan2, m, s);
            o.status = ST_PROJECTED;
         end else begin
            o.status = ST_INSIDE;
         end
      end
      return o;
   endfunction

   function automatic req_type make_contact(input logic [MIND_W-1:0] mind, input int mode);
      req_type c;
      int unsigned base;
      base = (mind == 0) ? 1 : mind;
      c.offset_normal = -$urandom_range(0, 1 << 22);
      c.offset_tan1 = $urandom_range(0, 1 << 23) - (1 << 22);
      c.offset_tan2 = $urandom_range(0, 1 << 23) - (1 << 22);
      c.diag_normal = base + $urandom_range(0, 1 << 20);
      c.diag_tan1 = base + $urandom_range(0, 1 << 20);
      c.diag_tan2 = base + $urandom_range(0, 1 << 20);
      c.friction_coef = MU_W'($urandom_range(0, (1 << MU_W) - 1));
      case (mode)
         0: begin
            // any bit pattern at all
            c.offset_normal = $urandom;
            c.offset_tan1 = $urandom;
            c.offset_tan2 = $urandom;
            c.diag_normal = $urandom;
            c.diag_tan1 = $urandom;
            c.diag_tan2 = $urandom;
         end
         1: c.offset_normal = $urandom_range(1, 32'h7FFF_FFFF);
         2: c.diag_tan1 = base - $urandom_range(1, 3);
         3: begin
            // huge offsets over small diagonals saturate
            c.offset_tan1 = $urandom;
            c.offset_tan2 = $urandom;
            c.offset_normal = -$urandom_range(0, 32'h7FFF_FFFF);
            c.diag_normal = base + $urandom_range(0, 16);
            c.diag_tan1 = base + $urandom_range(0, 16);
            c.diag_tan2 = base + $urandom_range(0, 16);
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic req_type contact(input logic [31:0] q0, q1, q2, d0, d1, d2,
                                       input logic [MU_W-1:0] mu);
      req_type c;
      c = '{q0, q1, q2, d0, d1, d2, mu};
      return c;
   endfunction

   function automatic bit idle_now();
      if (cyc > 3000 && cyc < 6000) return 1'b0;
      return $urandom_range(0, 99) < 28;
   endfunction

   // request driver: holds the item while stalled
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            force_expect_q.push_back(predict_force(req_data, min_diag));
         if (!req_valid || !req_stall) begin
            if (contact_q.size() != 0 && !idle_now()) begin
               req_valid <= 1'b1;
               req_data <= contact_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      rsp_type exp_f;
      if (!reset && rsp_valid && !rsp_stall) begin
         force_count <= force_count + 1;
         if (force_expect_q.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            failed <= 1'b1;
         end else begin
            exp_f = force_expect_q.pop_front();
            if (rsp_data.force_normal !== exp_f.force_normal) begin
               $error("force_normal expected %h actual %h", exp_f.force_normal,
                      rsp_data.force_normal);
               failed <= 1'b1;
            end
            if (rsp_data.force_tan1 !== exp_f.force_tan1) begin
               $error("force_tan1 expected %h actual %h", exp_f.force_tan1,
                      rsp_data.force_tan1);
               failed <= 1'b1;
            end
            if (rsp_data.force_tan2 !== exp_f.force_tan2) begin
               $error("force_tan2 expected %h actual %h", exp_f.force_tan2,
                      rsp_data.force_tan2);
               failed <= 1'b1;
            end
            if (rsp_data.status !== exp_f.status) begin
               $error("status expected %s actual %h", exp_f.status.name(),
                      rsp_data.status);
               failed <= 1'b1;
            end
         end
      end
      // one long hold-off so the pipe fills and stalls its input
      if (!hold_done && force_count == 300) begin
         hold_done <= 1'b1;
         hold_left <= 250;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= reset ? 1'b0 : idle_now();
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cyc >= CYC_LIMIT) begin
         $display("contact_diag_cone_projection_unit: mismatch");
         $finish;
      end
   end

   // wait on settled values so the last accept and result are seen
   task automatic drain();
      do @(negedge clock);
      while (contact_q.size() != 0 || req_valid || force_expect_q.size() != 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_min_diag(input logic [MIND_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      min_diag = v;
   endtask

   initial begin
      logic [MIND_W-1:0] settings[5];
      int mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      min_diag = 17'd1;
      cyc = 0;
      force_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      failed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed contacts at reset setting
      contact_q.push_back(contact(32'd1, 32'd5, 32'd5, 32'h10000, 32'h10000, 32'h10000, 20'h10000));
      contact_q.push_back(contact(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 20'h0));
      contact_q.push_back(contact(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 20'h10000));
      contact_q.push_back(contact(0, 32'h10000, 0, 32'h10000, 32'h10000, 32'h10000, 20'hFFFFF));
      contact_q.push_back(contact(-32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 20'h10000));
      contact_q.push_back(contact(-32'h10000, 0, 0, 32'h10000, 32'h8000_0000, 32'h10000, 20'h1));
      contact_q.push_back(contact(-32'h10000, 32'h10000, -32'h10000, 32'h10000, 32'h10000,
                                  32'h10000, 20'h10000));
      contact_q.push_back(contact(-32'h10000, 32'h100, 32'h100, 32'h10000, 32'h10000,
                                  32'h10000, 20'h10000));
      contact_q.push_back(contact(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1,
                                  32'd1, 20'hFFFFF));
      contact_q.push_back(contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h0));
      contact_q.push_back(contact(-32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1,
                                  32'd1, 20'hFFFFF));
      contact_q.push_back(contact(-32'h30000, 32'h40000, 32'h30000, 32'h10000, 32'h10000,
                                  32'h10000, 20'h8000));
      contact_q.push_back(contact(-32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000, 20'h0));
      contact_q.push_back(contact(-32'h10000, 0, 32'd1, 32'h10000, 32'h7FFF_FFFF, 32'h10000,
                                  20'h0));
      drain();

      settings[0] = 17'd1;
      settings[1] = MIND_W'($urandom_range(2, 65535));
      settings[2] = 17'd65536;
      settings[3] = 17'h1FFFF;
      settings[4] = 17'd0;
      for (int p = 0; p < 5; p++) begin
         write_min_diag(settings[p]);
         // diagonals around the threshold
         contact_q.push_back(contact(-32'h10000, 32'h10000, 0, 32'(settings[p]),
                                     32'(settings[p]), 32'(settings[p]), 20'h10000));
         contact_q.push_back(contact(-32'h10000, 32'h10000, 0, 32'(settings[p] - 17'd1),
                                     32'(settings[p]), 32'(settings[p]), 20'h10000));
         for (int i = 0; i < RAND_ITEMS / 5; i++) begin
            mode = $urandom_range(0, 19);
            contact_q.push_back(make_contact(settings[p], (mode < 4) ? mode : 4));
         end
         drain();
      end

      if (!failed && force_expect_q.size() == 0) begin
         $display("contact_diag_cone_projection_unit: match");
      end else begin
         $display("contact_diag_cone_projection_unit: mismatch");
      end
      $finish;
   end

endmodule
